// ===== src/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg - sliding window maximum shared definitions
// Sizes, payload types and the control word handed from the sequence
// counter to the top level.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int WIN_W        = 7;                    // window_size register width
    localparam int SEL_W        = $clog2(MAX_WINDOW);   // cell index width

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic        [WIN_W-1:0]        t_win;
    typedef logic        [SEL_W-1:0]        t_sel;

    // per-word decision made as a sample is taken in
    typedef struct packed {
        logic emit;     // this sample yields a result
        t_sel sel;      // cell that holds the window maximum
    } t_ctrl;

endpackage

// ===== src/swm_if.sv =====
// ----------------------------------------------------------------------------
// swm_in_if / swm_out_if - sample and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface swm_in_if import swm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    new_sequence;

    modport source (output valid, output sample, output new_sequence, input ready);
    modport sink   (input valid, input sample, input new_sequence, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

// ===== src/sliding_window_maximum.sv =====
// ----------------------------------------------------------------------------
// sliding_window_maximum - running maximum over the last window_size samples
// A chain of MAX_WINDOW compare cells keeps, in cell k, the maximum of the
// newest k+1 samples; the result is read from cell window-1.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  i_smp     in    valid / ready    sample (32b signed), new_sequence (1b)
//  o_res     out   valid / ready    window_max (32b signed)
//  cfg       in    i_cfg_we         i_cfg_data = window_size (7b)
//
//  One word per cycle while the input is not stalled: each accepted sample shifts
//  the whole cell chain once. A result follows its sample: the chain updates on accept,
//  then the selected cell is copied into the output register once it can take it.
//  Reset (synchronous, active low) sets window_size to 1 and empties the
//  sequence count; cell contents are not reset and are read only once filled.
//  The input stalls only when a result is waiting in the middle stage and the
//  output register is full and not being taken.
// ----------------------------------------------------------------------------
module sliding_window_maximum import swm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    swm_in_if.sink           i_smp,
    swm_out_if.source        o_res,
    input  logic             i_cfg_we,
    input  t_win             i_cfg_data
);

    // handshake terms
    logic    w_accept;      // sample word taken this edge
    logic    w_move;        // pending result moves into the output register
    t_ctrl   w_ctl;
    t_win    w_win_eff;

    // middle stage: a result is due from the chain
    logic    r_pend;
    t_sel    r_sel;

    // output register
    logic    r_out_valid;
    t_sample r_out_data;

    // chain taps: w_max[k] is max over the newest k+1 samples
    t_sample w_max [MAX_WINDOW];

    assign w_move      = r_pend && (!r_out_valid || o_res.ready);
    assign i_smp.ready = !r_pend || w_move;
    assign w_accept    = i_smp.valid && i_smp.ready;

    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_new_seq  (i_smp.new_sequence),
        .o_ctl      (w_ctl),
        .o_win_eff  (w_win_eff)
    );

    // cell 0 sees the new sample on both sides, so it simply loads it
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        if (g == 0) begin : g_head
            swm_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (w_accept),
                .i_sample (i_smp.sample),
                .i_prev   (i_smp.sample),
                .o_max    (w_max[g])
            );
        end else begin : g_body
            swm_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (w_accept),
                .i_sample (i_smp.sample),
                .i_prev   (w_max[g-1]),
                .o_max    (w_max[g])
            );
        end
    end

    // middle stage control; the cell index is latched so the read
    // does not depend on the register after the sample is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (w_accept) begin
            r_pend <= w_ctl.emit;
        end else if (w_move) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sel <= w_ctl.sel;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_data <= w_max[r_sel];
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.window_max = r_out_data;

`ifndef ASSERT_OFF
    // a sample that completes its window must leave a result due
    a_emit_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ctl.emit) |=> r_pend)
        else $error("result due but middle stage empty");

    // the first sample of a fresh sequence yields no result unless the window is 1
    a_new_seq_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_smp.new_sequence && (w_win_eff != t_win'(1))) |=> !r_pend)
        else $error("result after new sequence before window filled");

    // the output register is only loaded from the middle stage
    a_out_from_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_pend))
        else $error("output valid without a pending result");

    // a pending result is never overwritten while it cannot move
    a_pend_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !w_move) |-> !w_accept)
        else $error("sample taken over a stuck pending result");
`endif

endmodule

// ===== src/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell - one stage of the running maximum chain
// Holds the maximum of the newest k+1 samples; on a shift it takes the
// larger of the incoming sample and its neighbour's value.
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_shift,
    input  t_sample i_sample,
    input  t_sample i_prev,
    output t_sample o_max
);

    t_sample r_max;
    t_sample n_max;

    assign n_max = (i_sample > i_prev) ? i_sample : i_prev;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_max <= n_max;
        end
    end

    assign o_max = r_max;

endmodule

// ===== src/swm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swm_ctrl - window register and sequence counter
// Holds window_size, clamps it to 1..MAX_WINDOW and counts samples of the
// current sequence, saturating at the window.
// ----------------------------------------------------------------------------
module swm_ctrl import swm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  t_win  i_cfg_data,
    input  logic  i_accept,
    input  logic  i_new_seq,
    output t_ctrl o_ctl,
    output t_win  o_win_eff
);

    localparam t_win WIN_ONE = t_win'(1);
    localparam t_win WIN_MAX = t_win'(MAX_WINDOW);

    t_win r_window;
    t_win r_seen;
    t_win n_seen;
    t_win w_eff;
    t_win w_base;

    always_comb begin
        if (r_window == '0) begin
            w_eff = WIN_ONE;
        end else if (r_window > WIN_MAX) begin
            w_eff = WIN_MAX;
        end else begin
            w_eff = r_window;
        end
    end

    always_comb begin
        w_base = i_new_seq ? '0 : r_seen;
        if (w_base < w_eff) begin
            n_seen = w_base + WIN_ONE;
        end else begin
            n_seen = w_eff;
        end
    end

    assign o_ctl.emit = (n_seen >= w_eff);
    assign o_ctl.sel  = SEL_W'(w_eff - WIN_ONE);
    assign o_win_eff  = w_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WIN_ONE;
            r_seen   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
            if (i_accept) begin
                r_seen <= n_seen;
            end
        end
    end

endmodule
